// ===== rtl/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg: shared definitions for the byte pipe
// Sizes, operation and status codes, and the command and status records
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pbf_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int MAX_ENDS     = 255;

  localparam int IDX_W      = $clog2(BUFFER_DEPTH);
  localparam int FILL_CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CNT_W      = $clog2(MAX_ENDS + 1);

  localparam int DATA_W   = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 11;

  localparam int S_TDATA_W = DATA_W;
  localparam int S_TUSER_W = OP_W + 1;
  localparam int M_TDATA_W = ((DATA_W + FILL_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - DATA_W - FILL_W;
  localparam int M_TUSER_W = STATUS_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ADD   = 2'd2,
    OP_CLOSE = 2'd3
  } pbf_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK            = 3'd0,
    STS_EMPTY_RETRY   = 3'd1,
    STS_END_OF_STREAM = 3'd2,
    STS_FULL_RETRY    = 3'd3,
    STS_BROKEN        = 3'd4,
    STS_RELEASED      = 3'd5
  } pbf_status_e;

  typedef struct packed {
    logic accept;  // an input beat is taken this cycle
    logic load;    // the pending result moves into the output register
  } pbf_cmd_t;

  typedef struct packed {
    logic out_valid;  // the output register holds a result not yet taken
  } pbf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbf_ram.sv =====
// ----------------------------------------------------------------------------
// pbf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pbf_datapath.sv =====
// ----------------------------------------------------------------------------
// pbf_datapath: ring buffer indices, end counts and output register
// Works out the status of each accepted operation, updates the pipe state
// and the ring memory, and assembles the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_datapath
  import pbf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pbf_cmd_t             cmd_i,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  input  wire logic [S_TUSER_W-1:0] s_tuser_i,
  input  wire logic                 s_tlast_i,
  input  wire logic                 m_tready_i,
  output logic      [M_TDATA_W-1:0] m_tdata_o,
  output logic      [M_TUSER_W-1:0] m_tuser_o,
  output logic                      m_tlast_o,
  output logic                      m_tvalid_o,
  output pbf_stat_t                 stat_o
);

  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]      wr_idx_q, wr_idx_d;
  logic [FILL_CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]      rcnt_q, rcnt_d;
  logic [CNT_W-1:0]      wcnt_q, wcnt_d;

  pbf_status_e res_status_q, res_status_d;
  logic        res_done_q, res_done_d;
  logic        res_rd_q, res_rd_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_byte_q;
  pbf_status_e       out_status_q;
  logic [FILL_W-1:0] out_fill_q;
  logic              out_done_q;

  pbf_op_e           op;
  logic              wside;
  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;

  assign op    = pbf_op_e'(s_tuser_i[OP_W-1:0]);
  assign wside = s_tuser_i[OP_W];

  always_comb begin
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    fill_d       = fill_q;
    rcnt_d       = rcnt_q;
    wcnt_d       = wcnt_q;
    res_status_d = STS_OK;
    res_done_d   = 1'b0;
    res_rd_d     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    case (op)
      OP_WRITE: begin
        if (rcnt_q == '0) begin
          res_status_d = STS_BROKEN;
        end else if (fill_q == FILL_CNT_W'(BUFFER_DEPTH)) begin
          res_status_d = STS_FULL_RETRY;
        end else begin
          ram_we     = cmd_i.accept;
          wr_idx_d   = (wr_idx_q == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
          fill_d     = fill_q + 1'b1;
          res_done_d = s_tlast_i;
        end
      end
      OP_READ: begin
        if (fill_q != '0) begin
          ram_re     = cmd_i.accept;
          res_rd_d   = 1'b1;
          rd_idx_d   = (rd_idx_q == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
          fill_d     = fill_q - 1'b1;
          res_done_d = s_tlast_i;
        end else if (wcnt_q == '0) begin
          res_status_d = STS_END_OF_STREAM;
        end else begin
          res_status_d = STS_EMPTY_RETRY;
        end
      end
      OP_ADD: begin
        if (wside) begin
          if (wcnt_q < CNT_W'(MAX_ENDS)) wcnt_d = wcnt_q + 1'b1;
        end else begin
          if (rcnt_q < CNT_W'(MAX_ENDS)) rcnt_d = rcnt_q + 1'b1;
        end
      end
      OP_CLOSE: begin
        if (wside) begin
          if (wcnt_q != '0) wcnt_d = wcnt_q - 1'b1;
        end else begin
          if (rcnt_q != '0) rcnt_d = rcnt_q - 1'b1;
        end
        if ((rcnt_d == '0) && (wcnt_d == '0)) res_status_d = STS_RELEASED;
      end
      default: begin
        res_status_d = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      fill_q   <= '0;
      rcnt_q   <= '0;
      wcnt_q   <= '0;
    end else if (cmd_i.accept) begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      fill_q   <= fill_d;
      rcnt_q   <= rcnt_d;
      wcnt_q   <= wcnt_d;
    end
  end

  // Result fields are registered here while the ring read completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= res_status_d;
      res_done_q   <= res_done_d;
      res_rd_q     <= res_rd_d;
    end
  end

  pbf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (s_tdata_i[DATA_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The pipe state is frozen between accept and load, so fill_q is the
  // level after the item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q   <= res_rd_q ? ram_rdata : '0;
      out_status_q <= res_status_q;
      out_fill_q   <= FILL_W'(fill_q);
      out_done_q   <= res_done_q;
    end
  end

  assign m_tdata_o        = {{M_PAD_W{1'b0}}, out_fill_q, out_byte_q};
  assign m_tuser_o        = out_status_q;
  assign m_tlast_o        = out_done_q;
  assign m_tvalid_o       = out_valid_q;
  assign stat_o.out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/pbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbf_ctrl: byte pipe controller
// Takes one operation, waits for the ring read, then hands the result to
// the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_ctrl
  import pbf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  input  wire logic      m_tready_i,
  input  wire pbf_stat_t stat_i,
  output logic           s_tready_o,
  output pbf_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    s_tready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
        if (s_tvalid_i) state_d = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.load = !stat_i.out_valid || m_tready_i;
        if (cmd_o.load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pipe_byte_fifo_with_end_counts.sv =====
// ----------------------------------------------------------------------------
// pipe_byte_fifo_with_end_counts: byte pipe with reader and writer end counts
// Ring-buffer byte FIFO that answers write, read, add-reference and close
// operations with one result beat each.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input beat carries one operation and gives exactly one result beat.
// An operation is taken, its result waits on the registered read port of
// the ring memory, and the result is then loaded into the output register;
// a result still held in the output register stalls the load. A new
// operation is taken while the previous result waits in the output
// register. Retry statuses leave the pipe unchanged.
module pipe_byte_fifo_with_end_counts
  import pbf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,  // data_byte
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser_i,  // operation[1:0], write_side[2]
  input  wire logic                 s_axis_tlast_i,  // request_end
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [M_TDATA_W-1:0] m_axis_tdata_o,  // read_byte[7:0], fill_level[18:8]
  output logic      [M_TUSER_W-1:0] m_axis_tuser_o,  // status[2:0]
  output logic                      m_axis_tlast_o   // transfer_done
);

  pbf_cmd_t  cmd;
  pbf_stat_t stat;

  pbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  pbf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tlast_i  (s_axis_tlast_i),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .stat_o     (stat)
  );

`ifndef SYNTHESIS
  // Only one operation is in flight: nothing is taken while its result is pending.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !s_axis_tready_o)
    else $error("input taken while a result was still pending");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> m_axis_tvalid_o)
    else $error("loaded result not presented");

  // A failed transfer moves no byte and reports no completed request.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != STS_OK)) |->
      (!m_axis_tlast_o && (m_axis_tdata_o[DATA_W-1:0] == '0)))
    else $error("failed operation reported data or completion");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[DATA_W+FILL_W-1:DATA_W] <= FILL_W'(BUFFER_DEPTH)))
    else $error("fill level beyond buffer depth");
`endif

endmodule

`default_nettype wire
